[hw/rtl/bba_pkg.sv]
// Shared types, constants and helper functions for the bitmap block allocator.
package bba_pkg;

  // Default geometry
  localparam int NUM_BLOCKS_DEF     = 512;
  localparam int RESERVED_START_DEF = 0;
  localparam int RESERVED_COUNT_DEF = 2;

  // Port field widths
  localparam int CMD_W      = 2;
  localparam int BLK_ID_W   = 10;
  localparam int STATUS_W   = 2;
  localparam int GRANT_W    = 9;
  localparam int COUNT_W    = 10;

  // Map word geometry: 32 blocks per memory word
  localparam int WORD_W     = 32;
  localparam int OFF_W      = $clog2(WORD_W);
  localparam int WIDX_MAX_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_USED  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  // Update of one full-word summary bit
  typedef struct packed {
    logic                  we;
    logic [WIDX_MAX_W-1:0] idx;
    logic                  full;
  } sum_upd_t;

  // Number of reserved blocks that lie inside the map
  function automatic int reserved_used(input int num, input int rs, input int rc);
    int n;
    n = 0;
    if (rs < num) begin
      n = ((num - rs) < rc) ? (num - rs) : rc;
    end
    return n;
  endfunction

  // Reset contents of one map word: reserved blocks and padding past the end are set
  function automatic logic [WORD_W-1:0] init_word(input logic [WIDX_MAX_W-1:0] widx,
                                                  input int num, input int rs,
                                                  input int rc);
    logic [WORD_W-1:0] w;
    int base;
    int idx;
    base = int'(widx) * WORD_W;
    for (int b = 0; b < WORD_W; b++) begin
      idx  = base + b;
      w[b] = (idx >= num) || ((idx >= rs) && (idx < rs + rc));
    end
    return w;
  endfunction

  // Offset of the lowest clear bit in a word
  function automatic logic [OFF_W-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [OFF_W-1:0] off;
    off = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        off = OFF_W'(i);
      end
    end
    return off;
  endfunction

endpackage

[hw/rtl/bba_map_ram.sv]
// Bitmap word memory: one write port, one read port, registered read data.
module bba_map_ram #(
  parameter int NUM_WORDS = 16,
  parameter int WIDX_W    = 4
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [WIDX_W-1:0]          wr_addr,
  input  logic [bba_pkg::WORD_W-1:0] wdata,
  input  logic                       rd_en,
  input  logic [WIDX_W-1:0]          rd_addr,
  output logic [bba_pkg::WORD_W-1:0] rdata
);
  import bba_pkg::*;

  logic [WORD_W-1:0] mem [NUM_WORDS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/bba_summary.sv]
// Per-word full flags and lowest non-full word search.
module bba_summary #(
  parameter int NUM_WORDS = 16,
  parameter int WIDX_W    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  bba_pkg::sum_upd_t upd,
  output logic              any_free,
  output logic [WIDX_W-1:0] free_word
);
  import bba_pkg::*;

  logic [NUM_WORDS-1:0] full;

  // Flag update; the init sweep writes every flag before first use
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= '0;
    end else if (upd.we) begin
      full[upd.idx[WIDX_W-1:0]] <= upd.full;
    end
  end

  // Lowest word with a clear bit
  always_comb begin
    any_free  = 1'b0;
    free_word = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (!full[i]) begin
        any_free  = 1'b1;
        free_word = WIDX_W'(i);
      end
    end
  end

endmodule

[hw/rtl/bitmap_block_allocator.sv]
// Top level of the first-fit bitmap block allocator.
//
//   channel  signals                                        handshake
//   command  cmd, blk_num                                   start && !busy
//   result   status, granted_block, used_count, free_count  done, one cycle
//
// An allocate, request or release that touches the map reads the map word,
// then modifies it, writes it back and registers the result.
// Commands settled up front (map full, block out of range, unused code) answer
// in the cycle after acceptance. The next command is taken in the cycle done
// is high. After reset an init sweep writes one map word per cycle, over every
// word of the map, with busy high. Results cannot be held off.
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS     = bba_pkg::NUM_BLOCKS_DEF,
  parameter int RESERVED_START = bba_pkg::RESERVED_START_DEF,
  parameter int RESERVED_COUNT = bba_pkg::RESERVED_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [bba_pkg::CMD_W-1:0]    cmd,
  input  logic [bba_pkg::BLK_ID_W-1:0] blk_num,
  output logic                         done,
  output logic [bba_pkg::STATUS_W-1:0] status,
  output logic [bba_pkg::GRANT_W-1:0]  granted_block,
  output logic [bba_pkg::COUNT_W-1:0]  used_count,
  output logic [bba_pkg::COUNT_W-1:0]  free_count
);
  import bba_pkg::*;

  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int IDX_W     = WIDX_W + OFF_W;
  localparam int CMP_W     = ((IDX_W > BLK_ID_W) ? IDX_W : BLK_ID_W) + 1;
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int RES_USED  = reserved_used(NUM_BLOCKS, RESERVED_START, RESERVED_COUNT);

  typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_EXEC} state_t;

  state_t            state;
  logic [WIDX_W-1:0] init_idx;
  cmd_t              op;
  logic [WIDX_W-1:0] word;
  logic [OFF_W-1:0]  off;
  logic [CNT_W-1:0]  used_total;

  // Map memory and summary hookup
  logic              rd_en;
  logic [WIDX_W-1:0] rd_addr;
  logic [WORD_W-1:0] rdata;
  logic              wr_en;
  logic [WIDX_W-1:0] wr_addr;
  logic [WORD_W-1:0] wdata;
  sum_upd_t          upd;
  logic              any_free;
  logic [WIDX_W-1:0] free_word;

  bba_map_ram #(
    .NUM_WORDS (NUM_WORDS),
    .WIDX_W    (WIDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wdata   (wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rdata   (rdata)
  );

  bba_summary #(
    .NUM_WORDS (NUM_WORDS),
    .WIDX_W    (WIDX_W)
  ) u_summary (
    .clk       (clk),
    .rst       (rst),
    .upd       (upd),
    .any_free  (any_free),
    .free_word (free_word)
  );

  // Command decode at acceptance
  logic             accept;
  cmd_t             cmd_in;
  logic [CMP_W-1:0] blk_ext;
  logic             in_range;
  logic [IDX_W-1:0] blk_idx;
  logic             go_exec;
  status_t          imm_status;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign cmd_in   = cmd_t'(cmd);
  assign blk_ext  = CMP_W'(blk_num);
  assign in_range = (blk_ext < CMP_W'(NUM_BLOCKS));
  assign blk_idx  = IDX_W'(blk_ext);

  always_comb begin
    go_exec    = 1'b0;
    imm_status = STAT_OK;
    unique case (cmd_in) inside
      CMD_ALLOC: begin
        go_exec    = any_free;
        imm_status = STAT_FULL;
      end
      CMD_REQUEST, CMD_RELEASE: begin
        go_exec    = in_range;
        imm_status = STAT_RANGE;
      end
      default: begin
        go_exec    = 1'b0;
        imm_status = STAT_OK;
      end
    endcase
  end

  assign rd_en   = accept;
  assign rd_addr = (cmd_in == CMD_ALLOC) ? free_word : blk_idx[IDX_W-1:OFF_W];

  // Read-modify-write of the fetched map word
  logic [OFF_W-1:0]  zero_off;
  logic              cur_bit;
  logic              ex_we;
  logic [WORD_W-1:0] ex_wdata;
  status_t           ex_status;
  logic [IDX_W-1:0]  ex_grant;
  logic [CNT_W-1:0]  used_next;

  assign zero_off = first_zero(rdata);
  assign cur_bit  = rdata[off];

  always_comb begin
    ex_we     = 1'b0;
    ex_wdata  = rdata;
    ex_status = STAT_OK;
    ex_grant  = '0;
    used_next = used_total;
    case (op)
      CMD_ALLOC: begin
        ex_we     = 1'b1;
        ex_wdata  = rdata | (WORD_W'(1) << zero_off);
        ex_grant  = {word, zero_off};
        used_next = used_total + CNT_W'(1);
      end
      CMD_REQUEST: begin
        if (cur_bit) begin
          ex_status = STAT_USED;
        end else begin
          ex_we     = 1'b1;
          ex_wdata  = rdata | (WORD_W'(1) << off);
          ex_grant  = {word, off};
          used_next = used_total + CNT_W'(1);
        end
      end
      CMD_RELEASE: begin
        ex_grant = {word, off};
        if (cur_bit) begin
          ex_we     = 1'b1;
          ex_wdata  = rdata & ~(WORD_W'(1) << off);
          used_next = used_total - CNT_W'(1);
        end
      end
      default: begin
        ex_we = 1'b0;
      end
    endcase
  end

  // Write port and summary update: init sweep or write-back
  logic [WORD_W-1:0] init_data;

  assign init_data = init_word(WIDX_MAX_W'(init_idx), NUM_BLOCKS, RESERVED_START,
                               RESERVED_COUNT);

  always_comb begin
    if (state == ST_INIT) begin
      wr_en   = 1'b1;
      wr_addr = init_idx;
      wdata   = init_data;
    end else begin
      wr_en   = (state == ST_EXEC) && ex_we;
      wr_addr = word;
      wdata   = ex_wdata;
    end
    upd.we   = wr_en;
    upd.idx  = WIDX_MAX_W'(wr_addr);
    upd.full = &wdata;
  end

  // Control state and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      init_idx   <= '0;
      used_total <= CNT_W'(RES_USED);
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_INIT: begin
          init_idx <= init_idx + WIDX_W'(1);
          if (init_idx == WIDX_W'(NUM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op   <= cmd_in;
            word <= rd_addr;
            off  <= blk_idx[OFF_W-1:0];
            if (go_exec) begin
              state <= ST_EXEC;
            end else begin
              done          <= 1'b1;
              status        <= imm_status;
              granted_block <= '0;
              used_count    <= COUNT_W'(used_total);
              free_count    <= COUNT_W'(CNT_W'(NUM_BLOCKS) - used_total);
            end
          end
        end
        ST_EXEC: begin
          state         <= ST_IDLE;
          done          <= 1'b1;
          status        <= ex_status;
          granted_block <= GRANT_W'(ex_grant);
          used_count    <= COUNT_W'(used_next);
          free_count    <= COUNT_W'(CNT_W'(NUM_BLOCKS) - used_next);
          used_total    <= used_next;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
